>>> hdl/nrsh_pkg.sv
// nrsh_pkg: shared types and constants for the nearest ray/segment hit block
// no dependencies
`default_nettype none

package nrsh_pkg;

  localparam int unsigned MaxEdgesDef = 64;
  localparam int unsigned CoordW      = 32;
  localparam int unsigned TolW        = 16;
  localparam int unsigned BaseW       = 33;
  localparam int unsigned SpanW       = 34;
  localparam int unsigned WideW       = 70;
  localparam int unsigned TimeW       = 32;

  localparam logic [18:0]      ShrinkQ32 = 19'd429497;
  localparam logic [TimeW-1:0] UnitQ16   = 32'h0001_0000;
  localparam logic [TolW-1:0]  TolReset  = 16'd1;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_CAST  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [CoordW-1:0] first_x;
    logic signed [CoordW-1:0] first_y;
    logic signed [CoordW-1:0] second_x;
    logic signed [CoordW-1:0] second_y;
    logic                     clamp_to_unit;
  } in_word_t;

  typedef struct packed {
    logic [TimeW-1:0] hit_time;
    logic             hit_found;
  } out_word_t;

  typedef struct packed {
    logic signed [BaseW-1:0] px;
    logic signed [BaseW-1:0] py;
    logic signed [SpanW-1:0] ex;
    logic signed [SpanW-1:0] ey;
  } edge_t;

  localparam int unsigned EdgeW = $bits(edge_t);

  typedef struct packed {
    logic      done;
    out_word_t res;
  } cast_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ADD  = 4'b0010,
    ST_CAST = 4'b0100,
    ST_PUT  = 4'b1000
  } top_state_e;

  typedef enum logic [7:0] {
    SH_IDLE = 8'b0000_0001,
    SH_NORM = 8'b0000_0010,
    SH_SQX  = 8'b0000_0100,
    SH_SQY  = 8'b0000_1000,
    SH_ROOT = 8'b0001_0000,
    SH_NUM  = 8'b0010_0000,
    SH_DIV  = 8'b0100_0000,
    SH_FIN  = 8'b1000_0000
  } shr_state_e;

  typedef enum logic [8:0] {
    CA_IDLE = 9'b0_0000_0001,
    CA_RD   = 9'b0_0000_0010,
    CA_LD   = 9'b0_0000_0100,
    CA_MUL  = 9'b0_0000_1000,
    CA_SGN  = 9'b0_0001_0000,
    CA_CHK  = 9'b0_0010_0000,
    CA_DIV  = 9'b0_0100_0000,
    CA_UPD  = 9'b0_1000_0000,
    CA_DONE = 9'b1_0000_0000
  } cast_state_e;

endpackage

`default_nettype wire

>>> hdl/nrsh_ram.sv
// nrsh_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none

module nrsh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/nrsh_shrink.sv
// nrsh_shrink: pulls both ends of a new edge in by 0.0001 along its direction
// depends on nrsh_pkg; sequential normalize, square root and short divide
`default_nettype none

module nrsh_shrink import nrsh_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [CoordW-1:0] start_x_i,
  input  wire logic signed [CoordW-1:0] start_y_i,
  input  wire logic signed [CoordW-1:0] end_x_i,
  input  wire logic signed [CoordW-1:0] end_y_i,
  output logic                          done_o,
  output edge_t                         edge_o
);

  shr_state_e state_q, state_d;
  logic [32:0] ax_q, ax_d, ay_q, ay_d;
  logic [63:0] acc_q, acc_d, root_q, root_d, bit_q, bit_d;
  logic [4:0]  iter_q, iter_d;
  logic [50:0] num_q, num_d;
  logic [1:0]  step_q, step_d;
  logic [2:0]  quo_q, quo_d, qx_q, qx_d, qy_q, qy_d;
  logic        axis_q, axis_d;

  logic signed [SpanW-1:0] sx_w, sy_w, fx_w, fy_w, dx_w, dy_w, ox_w, oy_w, px_w, py_w;
  logic [32:0] dx_abs, dy_abs, m_w;
  logic [63:0] trial_w;
  logic [61:0] sq_w;
  logic [30:0] sel_w;
  logic [49:0] prod_w, dsh_w;
  logic [31:0] len_w;
  logic        ge_w;

  assign sx_w = {{(SpanW-CoordW){start_x_i[CoordW-1]}}, start_x_i};
  assign sy_w = {{(SpanW-CoordW){start_y_i[CoordW-1]}}, start_y_i};
  assign fx_w = {{(SpanW-CoordW){end_x_i[CoordW-1]}}, end_x_i};
  assign fy_w = {{(SpanW-CoordW){end_y_i[CoordW-1]}}, end_y_i};
  assign dx_w = fx_w - sx_w;
  assign dy_w = fy_w - sy_w;
  assign dx_abs = dx_w[SpanW-1] ? 33'(-dx_w) : 33'(dx_w);
  assign dy_abs = dy_w[SpanW-1] ? 33'(-dy_w) : 33'(dy_w);

  assign m_w     = (ax_q > ay_q) ? ax_q : ay_q;
  assign trial_w = root_q + bit_q;
  assign len_w   = root_q[31:0];
  assign sel_w   = axis_q ? ay_q[30:0] : ax_q[30:0];
  assign sq_w    = (state_q == SH_SQX) ? ax_q[30:0] * ax_q[30:0] : ay_q[30:0] * ay_q[30:0];
  assign prod_w  = sel_w * ShrinkQ32;
  assign dsh_w   = {2'b00, len_w, 16'b0} << step_q;
  assign ge_w    = num_q >= {1'b0, dsh_w};

  always_comb begin
    state_d = state_q;
    ax_d    = ax_q;
    ay_d    = ay_q;
    acc_d   = acc_q;
    root_d  = root_q;
    bit_d   = bit_q;
    iter_d  = iter_q;
    num_d   = num_q;
    step_d  = step_q;
    quo_d   = quo_q;
    qx_d    = qx_q;
    qy_d    = qy_q;
    axis_d  = axis_q;
    case (state_q)
      SH_IDLE: begin
        if (start_i) begin
          ax_d = dx_abs;
          ay_d = dy_abs;
          if (dx_abs == '0 && dy_abs == '0) begin
            qx_d    = '0;
            qy_d    = '0;
            state_d = SH_FIN;
          end else begin
            state_d = SH_NORM;
          end
        end
      end
      SH_NORM: begin
        if (m_w[32:31] != 2'b00) begin
          ax_d = ax_q >> 1;
          ay_d = ay_q >> 1;
        end else if (!m_w[30]) begin
          ax_d = ax_q << 1;
          ay_d = ay_q << 1;
        end else begin
          state_d = SH_SQX;
        end
      end
      SH_SQX: begin
        acc_d   = {2'b00, sq_w};
        state_d = SH_SQY;
      end
      SH_SQY: begin
        acc_d   = acc_q + {2'b00, sq_w};
        root_d  = '0;
        bit_d   = 64'd1 << 62;
        iter_d  = '0;
        state_d = SH_ROOT;
      end
      SH_ROOT: begin
        if (acc_q >= trial_w) begin
          acc_d  = acc_q - trial_w;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d  = bit_q >> 2;
        iter_d = iter_q + 5'd1;
        if (iter_q == 5'd31) begin
          axis_d  = 1'b0;
          state_d = SH_NUM;
        end
      end
      SH_NUM: begin
        num_d   = {1'b0, prod_w} + {4'b0, len_w, 15'b0};
        step_d  = 2'd2;
        quo_d   = '0;
        state_d = SH_DIV;
      end
      SH_DIV: begin
        if (ge_w) begin
          num_d = num_q - {1'b0, dsh_w};
          quo_d = quo_q | (3'd1 << step_q);
        end
        step_d = step_q - 2'd1;
        if (step_q == 2'd0) begin
          if (axis_q) begin
            qy_d    = quo_d;
            state_d = SH_FIN;
          end else begin
            qx_d    = quo_d;
            axis_d  = 1'b1;
            state_d = SH_NUM;
          end
        end
      end
      SH_FIN: begin
        state_d = SH_IDLE;
      end
      default: begin
        state_d = SH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SH_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    acc_q  <= acc_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    iter_q <= iter_d;
    num_q  <= num_d;
    step_q <= step_d;
    quo_q  <= quo_d;
    qx_q   <= qx_d;
    qy_q   <= qy_d;
    axis_q <= axis_d;
  end

  assign ox_w = dx_w[SpanW-1] ? -SpanW'(qx_q) : SpanW'(qx_q);
  assign oy_w = dy_w[SpanW-1] ? -SpanW'(qy_q) : SpanW'(qy_q);
  assign px_w = fx_w - ox_w;
  assign py_w = fy_w - oy_w;

  assign done_o    = (state_q == SH_FIN);
  assign edge_o.px = px_w[BaseW-1:0];
  assign edge_o.py = py_w[BaseW-1:0];
  assign edge_o.ex = sx_w - fx_w + (ox_w <<< 1);
  assign edge_o.ey = sy_w - fy_w + (oy_w <<< 1);

endmodule

`default_nettype wire

>>> hdl/nrsh_cast.sv
// nrsh_cast: walks the edge store for one ray and keeps the nearest hit
// depends on nrsh_pkg; reads the edge ram, shared multiplier, serial divider
`default_nettype none

module nrsh_cast import nrsh_pkg::*; #(
  parameter int unsigned MaxEdges = MaxEdgesDef,
  localparam int unsigned CntW = $clog2(MaxEdges + 1),
  localparam int unsigned IdxW = (MaxEdges > 1) ? $clog2(MaxEdges) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [CoordW-1:0] org_x_i,
  input  wire logic signed [CoordW-1:0] org_y_i,
  input  wire logic signed [CoordW-1:0] dir_x_i,
  input  wire logic signed [CoordW-1:0] dir_y_i,
  input  wire logic                     clamp_i,
  input  wire logic [TolW-1:0]          tol_i,
  input  wire logic [CntW-1:0]          count_i,
  output logic                          rd_en_o,
  output logic [IdxW-1:0]               rd_addr_o,
  input  wire edge_t                    rd_data_i,
  output cast_stat_t                    stat_o
);

  cast_state_e state_q, state_d;
  logic [CntW-1:0]         idx_q, idx_d;
  logic signed [SpanW-1:0] wx_q, wx_d, wy_q, wy_d, ex_q, ex_d, ey_q, ey_d;
  logic signed [WideW-1:0] den_q, den_d, n1_q, n1_d, n2_q, n2_d;
  logic [2:0]              mstep_q, mstep_d;
  logic [WideW-1:0]        rem_q, rem_d;
  logic [TimeW-1:0]        quo_q, quo_d, best_q, best_d;
  logic [4:0]              dstep_q, dstep_d;
  logic                    found_q, found_d;

  logic signed [SpanW-1:0]   ox_w, oy_w, bx_w, by_w, ma_w, mb_w;
  logic signed [2*SpanW-1:0] p_w;
  logic signed [WideW-1:0]   pw_w, tol_w, r0_w;
  logic [WideW-1:0]          r2_w;
  logic [CntW-1:0]           idx_nxt;
  logic                      ge_w, pass_w;

  assign ox_w = {{(SpanW-CoordW){org_x_i[CoordW-1]}}, org_x_i};
  assign oy_w = {{(SpanW-CoordW){org_y_i[CoordW-1]}}, org_y_i};
  assign bx_w = {{(SpanW-CoordW){dir_x_i[CoordW-1]}}, dir_x_i};
  assign by_w = {{(SpanW-CoordW){dir_y_i[CoordW-1]}}, dir_y_i};

  always_comb begin
    case (mstep_q)
      3'd0: begin
        ma_w = ex_q;
        mb_w = by_w;
      end
      3'd1: begin
        ma_w = ey_q;
        mb_w = bx_w;
      end
      3'd2: begin
        ma_w = ex_q;
        mb_w = wy_q;
      end
      3'd3: begin
        ma_w = ey_q;
        mb_w = wx_q;
      end
      3'd4: begin
        ma_w = bx_w;
        mb_w = wy_q;
      end
      default: begin
        ma_w = by_w;
        mb_w = wx_q;
      end
    endcase
  end

  assign p_w    = ma_w * mb_w;
  assign pw_w   = {{(WideW-2*SpanW){p_w[2*SpanW-1]}}, p_w};
  assign tol_w  = {{(WideW-TolW-16){1'b0}}, tol_i, 16'b0};
  assign pass_w = (den_q > tol_w) && !n1_q[WideW-1] && (n1_q != '0) &&
                  !n2_q[WideW-1] && (n2_q != '0) && (n2_q < den_q);
  assign r0_w   = n1_q >>> 16;
  assign r2_w   = {rem_q[WideW-2:0], quo_q[TimeW-1]};
  assign ge_w   = r2_w >= WideW'(den_q);
  assign idx_nxt = idx_q + 1'b1;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    wx_d    = wx_q;
    wy_d    = wy_q;
    ex_d    = ex_q;
    ey_d    = ey_q;
    den_d   = den_q;
    n1_d    = n1_q;
    n2_d    = n2_q;
    mstep_d = mstep_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dstep_d = dstep_q;
    best_d  = best_q;
    found_d = found_q;
    case (state_q)
      CA_IDLE: begin
        if (start_i) begin
          best_d  = clamp_i ? UnitQ16 : '0;
          found_d = clamp_i;
          idx_d   = '0;
          state_d = (count_i == '0) ? CA_DONE : CA_RD;
        end
      end
      CA_RD: begin
        state_d = CA_LD;
      end
      CA_LD: begin
        wx_d    = {rd_data_i.px[BaseW-1], rd_data_i.px} - ox_w;
        wy_d    = {rd_data_i.py[BaseW-1], rd_data_i.py} - oy_w;
        ex_d    = rd_data_i.ex;
        ey_d    = rd_data_i.ey;
        mstep_d = '0;
        state_d = CA_MUL;
      end
      CA_MUL: begin
        case (mstep_q)
          3'd0: den_d = pw_w;
          3'd1: den_d = den_q - pw_w;
          3'd2: n1_d  = pw_w;
          3'd3: n1_d  = n1_q - pw_w;
          3'd4: n2_d  = pw_w;
          default: n2_d = n2_q - pw_w;
        endcase
        mstep_d = mstep_q + 3'd1;
        if (mstep_q == 3'd5) begin
          state_d = CA_SGN;
        end
      end
      CA_SGN: begin
        if (den_q[WideW-1]) begin
          den_d = -den_q;
          n1_d  = -n1_q;
          n2_d  = -n2_q;
        end
        state_d = CA_CHK;
      end
      CA_CHK: begin
        if (!pass_w) begin
          idx_d   = idx_nxt;
          state_d = (idx_nxt == count_i) ? CA_DONE : CA_RD;
        end else if (r0_w >= den_q) begin
          quo_d   = '1;
          state_d = CA_UPD;
        end else begin
          rem_d   = WideW'(r0_w);
          quo_d   = {n1_q[15:0], 16'b0};
          dstep_d = '0;
          state_d = CA_DIV;
        end
      end
      CA_DIV: begin
        rem_d   = ge_w ? (r2_w - WideW'(den_q)) : r2_w;
        quo_d   = {quo_q[TimeW-2:0], ge_w};
        dstep_d = dstep_q + 5'd1;
        if (dstep_q == 5'd31) begin
          state_d = CA_UPD;
        end
      end
      CA_UPD: begin
        if (!found_q || quo_q < best_q) begin
          best_d  = quo_q;
          found_d = 1'b1;
        end
        idx_d   = idx_nxt;
        state_d = (idx_nxt == count_i) ? CA_DONE : CA_RD;
      end
      CA_DONE: begin
        state_d = CA_IDLE;
      end
      default: begin
        state_d = CA_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CA_IDLE;
      found_q <= 1'b0;
      best_q  <= '0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
      best_q  <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    wx_q    <= wx_d;
    wy_q    <= wy_d;
    ex_q    <= ex_d;
    ey_q    <= ey_d;
    den_q   <= den_d;
    n1_q    <= n1_d;
    n2_q    <= n2_d;
    mstep_q <= mstep_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    dstep_q <= dstep_d;
  end

  assign rd_en_o             = (state_q == CA_RD);
  assign rd_addr_o           = idx_q[IdxW-1:0];
  assign stat_o.done         = (state_q == CA_DONE);
  assign stat_o.res.hit_time = found_q ? best_q : '0;
  assign stat_o.res.hit_found = found_q;

endmodule

`default_nettype wire

>>> hdl/nearest_ray_segment_hit.sv
// nearest_ray_segment_hit: top level, edge store ram, shrink unit and ray cast unit
// depends on nrsh_pkg, nrsh_ram, nrsh_shrink, nrsh_cast
// clear acts in the idle state; add runs normalize, a 32 step root and the two short divides
// cast: each stored edge goes through the shared multiplier, then the serial divider if it is a candidate
// one word at a time; a cast result waits in the output register while clear or add go on
// reset: edge count cleared, tolerance set to 1; edge ram contents are not cleared
`default_nettype none

module nearest_ray_segment_hit import nrsh_pkg::*; #(
  parameter int unsigned MaxEdges = MaxEdgesDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [TolW-1:0] cfg_data_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire in_word_t        in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output out_word_t            out_data_o
);

  localparam int unsigned CntW = $clog2(MaxEdges + 1);
  localparam int unsigned IdxW = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;

  top_state_e      state_q, state_d;
  in_word_t        in_q;
  logic [CntW-1:0] count_q, count_d;
  logic [TolW-1:0] tol_q;
  logic            out_valid_q, out_valid_d;
  out_word_t       out_q;
  logic            add_go_q, add_go_d, cast_go_q, cast_go_d;

  logic            accept_w, shr_done, rd_en, put_w;
  logic [IdxW-1:0] rd_addr;
  edge_t           new_edge, rd_edge;
  cast_stat_t      cast_stat;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept_w    = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign put_w       = (state_q == ST_PUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    add_go_d    = 1'b0;
    cast_go_d   = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept_w) begin
          case (in_data_i.kind)
            KIND_CLEAR: count_d = '0;
            KIND_ADD: begin
              if (count_q != CntW'(MaxEdges)) begin
                add_go_d = 1'b1;
                state_d  = ST_ADD;
              end
            end
            KIND_CAST: begin
              cast_go_d = 1'b1;
              state_d   = ST_CAST;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        if (shr_done) begin
          count_d = count_q + 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_CAST: begin
        if (cast_stat.done) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        if (put_w) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      tol_q       <= TolReset;
      out_valid_q <= 1'b0;
      add_go_q    <= 1'b0;
      cast_go_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      add_go_q    <= add_go_d;
      cast_go_q   <= cast_go_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tol_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      in_q <= in_data_i;
    end
    if (put_w) begin
      out_q <= cast_stat.res;
    end
  end

  nrsh_shrink u_shrink (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (add_go_q),
    .start_x_i (in_q.first_x),
    .start_y_i (in_q.first_y),
    .end_x_i   (in_q.second_x),
    .end_y_i   (in_q.second_y),
    .done_o    (shr_done),
    .edge_o    (new_edge)
  );

  nrsh_ram #(
    .Width (EdgeW),
    .Depth (MaxEdges)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    ((state_q == ST_ADD) && shr_done),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (new_edge),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_edge)
  );

  nrsh_cast #(
    .MaxEdges (MaxEdges)
  ) u_cast (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cast_go_q),
    .org_x_i   (in_q.first_x),
    .org_y_i   (in_q.first_y),
    .dir_x_i   (in_q.second_x),
    .dir_y_i   (in_q.second_y),
    .clamp_i   (in_q.clamp_to_unit),
    .tol_i     (tol_q),
    .count_i   (count_q),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_edge),
    .stat_o    (cast_stat)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// tb_top: self-checking bench for nearest_ray_segment_hit (edge store, ray cast)
// depends on nrsh_pkg and the rtl top; exact fixed point predictor and scoreboard class
`timescale 1ns / 1ps
`default_nettype none

class hit_board;
  nrsh_pkg::out_word_t pending_q[$];
  int errors;
  int checked;

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function void note_cast(nrsh_pkg::out_word_t w);
    pending_q.push_back(w);
  endfunction

  task check_word(nrsh_pkg::out_word_t got);
    nrsh_pkg::out_word_t want;
    if (pending_q.size() == 0) begin
      report($sformatf("unexpected word %h", got));
      return;
    end
    want = pending_q.pop_front();
    checked++;
    if (got.hit_time !== want.hit_time) begin
      report($sformatf("hit_time got %h want %h", got.hit_time, want.hit_time));
    end
    if (got.hit_found !== want.hit_found) begin
      report($sformatf("hit_found got %b want %b", got.hit_found, want.hit_found));
    end
  endtask
endclass

module tb_top;
  import nrsh_pkg::*;

  localparam int NEdges = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [TolW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_word_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_word_t out_data_o;

  hit_board board;
  logic signed [63:0] st_px[NEdges], st_py[NEdges], st_ex[NEdges], st_ey[NEdges];
  int edge_cnt;
  logic [15:0] tol;
  bit idle_on = 1'b1;
  int casts, adds, hits;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  nearest_ray_segment_hit u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i, .out_valid_o, .out_ready_i, .out_data_o
  );

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void shrink(input logic signed [63:0] dx, dy,
                                 output logic signed [63:0] ox, oy);
    logic [63:0] ax, ay, m, len, qx, qy;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    ox = 0;
    oy = 0;
    if (ax == 0 && ay == 0) return;
    m = ax > ay ? ax : ay;
    while (m >= 64'd1 << 31) begin
      ax >>= 1; ay >>= 1; m >>= 1;
    end
    while (m < 64'd1 << 30) begin
      ax <<= 1; ay <<= 1; m <<= 1;
    end
    len = int_sqrt(ax * ax + ay * ay);
    qx = (ax * 64'd429497 + (len << 15)) / (len << 16);
    qy = (ay * 64'd429497 + (len << 15)) / (len << 16);
    ox = dx < 0 ? -$signed(qx) : $signed(qx);
    oy = dy < 0 ? -$signed(qy) : $signed(qy);
  endfunction

  task automatic predict_word(in_word_t w);
    logic signed [63:0] sx, sy, fx, fy, ox, oy, wx, wy;
    logic signed [127:0] den, n1, n2;
    logic [127:0] q;
    logic [31:0] best, t;
    bit found;
    sx = w.first_x; sy = w.first_y; fx = w.second_x; fy = w.second_y;
    case (w.kind)
      KIND_CLEAR: edge_cnt = 0;
      KIND_ADD: begin
        adds++;
        if (edge_cnt < NEdges) begin
          shrink(fx - sx, fy - sy, ox, oy);
          st_px[edge_cnt] = fx - ox;
          st_py[edge_cnt] = fy - oy;
          st_ex[edge_cnt] = sx - fx + 2 * ox;
          st_ey[edge_cnt] = sy - fy + 2 * oy;
          edge_cnt++;
        end
      end
      KIND_CAST: begin
        casts++;
        found = w.clamp_to_unit;
        best = found ? UnitQ16 : 0;
        for (int i = 0; i < edge_cnt; i++) begin
          wx = st_px[i] - sx;
          wy = st_py[i] - sy;
          den = 128'(st_ex[i]) * fy - 128'(st_ey[i]) * fx;
          n1 = 128'(st_ex[i]) * wy - 128'(st_ey[i]) * wx;
          n2 = 128'(fx) * wy - 128'(fy) * wx;
          if (den < 0) begin
            den = -den; n1 = -n1; n2 = -n2;
          end
          if (den <= (128'(tol) << 16)) continue;
          if (n1 <= 0 || n2 <= 0 || n2 >= den) continue;
          q = (n1 <<< 16) / den;
          t = q > 128'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
          if (!found || t < best) begin
            best = t; found = 1;
          end
        end
        if (found) hits++;
        board.note_cast('{hit_time: found ? best : 32'd0, hit_found: found});
      end
      default: ;
    endcase
  endtask

  task automatic send_word(in_word_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predict_word(w);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (board.pending_q.size() != 0 && guard < 2000000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_tol(logic [15:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    tol = v;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 40)) - 20) << 16
                    | 32'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic in_word_t mk(logic [1:0] k, logic [31:0] a, b, c, d, logic cl);
    in_word_t w;
    w.kind = k; w.first_x = a; w.first_y = b; w.second_x = c; w.second_y = d;
    w.clamp_to_unit = cl;
    return w;
  endfunction

  task automatic random_phase(int n, int max_edges);
    in_word_t w;
    for (int i = 0; i < n; i++) begin
      w = mk(KIND_CAST, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
             $urandom_range(0, 1));
      case ($urandom_range(0, 19))
        0: w.kind = KIND_CLEAR;
        1: w.kind = 2'd3;
        2, 3, 4, 5, 6, 7, 8: if (edge_cnt < max_edges) w.kind = KIND_ADD;
        default: ;
      endcase
      send_word(w);
    end
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) board.check_word(out_data_o);
  end

  always @(posedge clk_i) begin
    if (!idle_on) out_ready_i <= 1'b1;
    else if ($urandom_range(0, 3) == 0) out_ready_i <= 1'b0;
    else out_ready_i <= 1'b1;
  end

  initial begin
    #100_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    board = new();
    tol = TolReset;
    edge_cnt = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: two sides of a square, casts from inside, parallel and zero direction
    send_word(mk(KIND_CAST, 0, 0, 32'h1_0000, 0, 1'b0));
    send_word(mk(KIND_CAST, 0, 0, 32'h1_0000, 0, 1'b1));
    send_word(mk(KIND_ADD, 32'h0002_0000, 32'hFFFE_0000, 32'h0002_0000, 32'h0002_0000, 0));
    send_word(mk(KIND_ADD, 32'hFFFE_0000, 32'hFFFE_0000, 32'hFFFE_0000, 32'h0002_0000, 0));
    send_word(mk(KIND_ADD, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 0));
    send_word(mk(KIND_ADD, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    send_word(mk(KIND_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1));
    send_word(mk(KIND_CAST, 0, 0, 32'h1_0000, 0, 1'b0));
    send_word(mk(KIND_CAST, 0, 0, 32'hFFFF_0000, 0, 1'b1));
    send_word(mk(KIND_CAST, 0, 0, 32'h0000_0001, 0, 1'b0));
    send_word(mk(KIND_CAST, 0, 0, 0, 32'h1_0000, 1'b0));
    send_word(mk(KIND_CAST, 0, 0, 0, 0, 1'b1));
    send_word(mk(KIND_CAST, 0, 0, 0, 0, 1'b0));
    send_word(mk(KIND_CAST, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1));
    send_word(mk(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    send_word(mk(KIND_CLEAR, 0, 0, 0, 0, 0));
    send_word(mk(KIND_CAST, 0, 0, 32'h1_0000, 0, 1'b1));
    for (int i = 0; i < NEdges + 2; i++)
      send_word(mk(KIND_ADD, 32'(i) << 16, 32'hFFFF_0000, 32'(i) << 16, 32'h1_0000, 0));
    send_word(mk(KIND_CAST, 32'hFFFF_8000, 0, 32'h1_0000, 32'h0000_0100, 1'b0));

    write_tol(16'd0);
    random_phase(400, 12);
    write_tol(16'hFFFF);
    random_phase(300, 12);
    write_tol(16'd300);
    random_phase(400, 8);
    drain();
    write_tol(16'd1);
    random_phase(300, 70);
    idle_on = 1'b0;
    random_phase(150, 10);

    drain();
    $display("covered %0d casts (%0d hit or clamped) and %0d adds, %0d results checked",
             casts, hits, adds, board.checked);
    if (board.pending_q.size() != 0)
      board.report($sformatf("%0d results never arrived", board.pending_q.size()));
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

`default_nettype wire
